// File: sv/utf8_to_cp1251_transcoder_top_defines.svh
// ---------------------------------------------------------------------------
// UTF-8 to CP1251 transcoder assertion macros
// Shared concurrent assertion forms, clocked on aclk and muted in reset.
// ---------------------------------------------------------------------------
`ifndef UTF8_TO_CP1251_TRANSCODER_TOP_DEFINES_SVH
`define UTF8_TO_CP1251_TRANSCODER_TOP_DEFINES_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define U8CP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define U8CP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/u8cp_pkg.sv
// ---------------------------------------------------------------------------
// UTF-8 to CP1251 transcoder package
// Result record, field widths, reset constants and the code page mapping.
// ---------------------------------------------------------------------------
package u8cp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned ACC_W   = 21;
    localparam int unsigned LEFT_W  = 2;

    localparam logic [COUNT_W-1:0] CAPACITY_RESET = 16'd160;

    localparam logic [ACC_W-1:0]  CYR_FIRST   = 21'h000410;
    localparam logic [ACC_W-1:0]  CYR_LAST    = 21'h00044F;
    localparam logic [BYTE_W-1:0] CYR_BASE    = 8'hC0;
    localparam logic [BYTE_W-1:0] UNKNOWN_CHR = 8'h3F;

    typedef struct packed {
        logic [COUNT_W-1:0] out_count;
        logic               is_end;
        logic [BYTE_W-1:0]  code_byte;
    } result_t;

    // Maps one Unicode code point to its Windows-1251 byte, '?' when absent (U+2039, U+203A, U+2192 differ).
    function automatic logic [BYTE_W-1:0] map_cp1251(input logic [ACC_W-1:0] cp);
        logic [BYTE_W-1:0] code;
        code = UNKNOWN_CHR;
        if (cp < 21'h000080) begin
            code = cp[BYTE_W-1:0];
        end else if (cp >= CYR_FIRST && cp <= CYR_LAST) begin
            code = CYR_BASE + BYTE_W'(cp - CYR_FIRST);
        end else begin
            case (cp)
                21'h000401: code = 8'hA8;
                21'h000451: code = 8'hB8;
                21'h000404: code = 8'hAA;
                21'h000454: code = 8'hBA;
                21'h000406: code = 8'hB2;
                21'h000456: code = 8'hB3;
                21'h000407: code = 8'hAF;
                21'h000457: code = 8'hBF;
                21'h000490: code = 8'hA5;
                21'h000491: code = 8'hB4;
                21'h0000A0, 21'h0000A4, 21'h0000A6, 21'h0000A7, 21'h0000A9,
                21'h0000AB, 21'h0000AC, 21'h0000AE, 21'h0000B0, 21'h0000B1,
                21'h0000B5, 21'h0000B6, 21'h0000B7, 21'h0000BB:
                    code = cp[BYTE_W-1:0];
                21'h002013: code = 8'h96;
                21'h002014: code = 8'h97;
                21'h002018: code = 8'h91;
                21'h002019: code = 8'h92;
                21'h00201C: code = 8'h93;
                21'h00201D: code = 8'h94;
                21'h002022: code = 8'h95;
                21'h002026: code = 8'h85;
                21'h002116: code = 8'hB9;
                21'h0020AC: code = 8'h88;
                21'h002122: code = 8'h99;
                21'h002192: code = 8'hBB;
                21'h00203A: code = 8'hBB;
                21'h002039: code = 8'hAB;
                default:    code = UNKNOWN_CHR;
            endcase
        end
        return code;
    endfunction

endpackage

// File: sv/u8cp_decoder.sv
// ---------------------------------------------------------------------------
// UTF-8 sequence decoder
// Holds the open sequence and the emitted count, builds at most one result per byte.
// ---------------------------------------------------------------------------
`include "utf8_to_cp1251_transcoder_top_defines.svh"

module u8cp_decoder (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic [u8cp_pkg::BYTE_W-1:0]  in_byte,
    input  logic [u8cp_pkg::COUNT_W-1:0] capacity,
    output logic                        res_valid,
    output u8cp_pkg::result_t           res
);
    import u8cp_pkg::*;

    logic [ACC_W-1:0]   code_acc_reg,   code_acc_next;
    logic [LEFT_W-1:0]  bytes_left_reg, bytes_left_next;
    logic [COUNT_W-1:0] emitted_reg,    emitted_next;

    logic               has_room;
    logic               emit_code;
    logic [ACC_W-1:0]   acc_shifted;

    // There is room while emitted + 1 is still below the buffer size.
    assign has_room    = ({1'b0, emitted_reg} + 17'd1) < {1'b0, capacity};
    assign acc_shifted = {code_acc_reg[ACC_W-7:0], in_byte[5:0]};

    always_comb begin
        code_acc_next   = code_acc_reg;
        bytes_left_next = bytes_left_reg;
        emitted_next    = emitted_reg;
        emit_code       = 1'b0;
        res_valid       = 1'b0;
        res             = '0;
        if (in_byte == '0) begin
            // Terminator: drop any partial sequence and report the count unless capacity is zero.
            code_acc_next   = '0;
            bytes_left_next = '0;
            emitted_next    = '0;
            res_valid       = (capacity != '0);
            res.is_end      = 1'b1;
            res.out_count   = emitted_reg;
        end else if (has_room) begin
            if (bytes_left_reg != '0) begin
                // Continuations are not checked; only six bits are kept.
                code_acc_next   = acc_shifted;
                bytes_left_next = bytes_left_reg - 2'd1;
                emit_code       = (bytes_left_reg == 2'd1);
            end else if (!in_byte[7]) begin
                code_acc_next = {13'd0, in_byte};
                emit_code     = 1'b1;
            end else if (in_byte[7:5] == 3'b110) begin
                code_acc_next   = {16'd0, in_byte[4:0]};
                bytes_left_next = 2'd1;
            end else if (in_byte[7:4] == 4'b1110) begin
                code_acc_next   = {17'd0, in_byte[3:0]};
                bytes_left_next = 2'd2;
            end else if (in_byte[7:3] == 5'b11110) begin
                code_acc_next   = {18'd0, in_byte[2:0]};
                bytes_left_next = 2'd3;
            end
            if (emit_code) begin
                emitted_next  = emitted_reg + 16'd1;
                res_valid     = 1'b1;
                res.code_byte = map_cp1251(code_acc_next);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_acc_reg   <= '0;
            bytes_left_reg <= '0;
            emitted_reg    <= '0;
        end else if (step) begin
            code_acc_reg   <= code_acc_next;
            bytes_left_reg <= bytes_left_next;
            emitted_reg    <= emitted_next;
        end
    end

    `U8CP_ASSERT_NEXT(a_clear_after_end, step && in_byte == '0,
        bytes_left_reg == '0 && emitted_reg == '0 && code_acc_reg == '0,
        "state not cleared after terminator")
    `U8CP_ASSERT_NOW(a_code_fits, step && in_byte != '0 && res_valid,
        ({1'b0, emitted_reg} + 17'd1) < {1'b0, capacity},
        "code byte emitted with no room")
    `U8CP_ASSERT_NOW(a_count_only_on_end, res_valid && !res.is_end,
        res.out_count == '0, "count set on a code byte")
    `U8CP_ASSERT_NOW(a_end_is_zero, res_valid && res.is_end,
        res.code_byte == '0, "terminator carries a nonzero byte")

endmodule

// File: sv/u8cp_out_stage.sv
// ---------------------------------------------------------------------------
// Result register
// Holds one result for the master side and reports when it can take another.
// ---------------------------------------------------------------------------
module u8cp_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  u8cp_pkg::result_t res,
    output logic              out_free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // code_byte [7:0], out_count [23:8]
    output logic              m_tlast    // is_end
);
    import u8cp_pkg::*;

    logic    vld_reg;
    result_t res_reg;

    assign out_free = !vld_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (out_free) begin
            vld_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {res_reg.out_count, res_reg.code_byte};
    assign m_tlast  = res_reg.is_end;

endmodule

// File: sv/utf8_to_cp1251_transcoder_top.sv
// ---------------------------------------------------------------------------
// UTF-8 to Windows-1251 transcoder, top level
// Input byte register, sequence decoder with code page map, result register.
// ---------------------------------------------------------------------------
// Path: an accepted byte is held in the input register, then its result in the result register that drives m_.
// Throughput: one byte per cycle while the master side does not stall; the decode state updates on each step.
// A stalled master side holds the result; one more byte waits in the input register.
// Reset (aresetn low, synchronous) empties both registers, closes any open sequence,
// clears the emitted count and sets the capacity register to 160.
module utf8_to_cp1251_transcoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Input byte channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // in_byte [7:0]
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // code_byte [7:0], out_count [23:8]
    output logic        m_tlast,    // is_end
    // Capacity register write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data    // capacity
);
    import u8cp_pkg::*;

    logic [COUNT_W-1:0] capacity_reg;
    logic               in_vld_reg;
    logic [BYTE_W-1:0]  in_byte_reg;

    logic               out_free;
    logic               step;
    logic               res_valid;
    result_t            res;

    // The capacity register takes a write request in any cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAPACITY_RESET;
        end else if (cfg_valid) begin
            capacity_reg <= cfg_data;
        end
    end

    // The held byte is decoded whenever the result register can take its
    // result, so the input register frees up in the same cycle.
    assign step     = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    u8cp_decoder u_decoder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .in_byte   (in_byte_reg),
        .capacity  (capacity_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Bytes that finish no code point consume a step but load no result.
    u8cp_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step && res_valid),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
